### design/trd_pkg.sv
// ----------------------------------------------------------------------------
// tls record deframer package
// Shared types and constants for the front classifier and back record engine.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam logic [14:0] REC_CAP     = 15'd16384;
  localparam logic [7:0]  CT_CCS      = 8'd20;
  localparam logic [7:0]  CT_ALERT    = 8'd21;
  localparam logic [7:0]  CT_HS       = 8'd22;
  localparam logic [7:0]  CT_APP      = 8'd23;
  localparam logic [7:0]  CT_HB       = 8'd24;
  localparam logic [15:0] VER_LO      = 16'h0300;
  localparam logic [15:0] VER_HI      = 16'h0304;
  localparam logic [7:0]  HS_CH       = 8'd1;
  localparam logic [7:0]  HS_SH       = 8'd2;
  localparam logic [7:0]  HS_CERT     = 8'd11;
  localparam logic [7:0]  HS_FIN      = 8'd20;
  localparam logic [7:0]  HS_UNKNOWN  = 8'd255;
  localparam logic [23:0] HELLO_MIN   = 24'd38;
  localparam logic [2:0]  VER_UNKNOWN = 3'd5;

  localparam logic [2:0] SS_IDLE  = 3'd0;
  localparam logic [2:0] SS_CH    = 3'd1;
  localparam logic [2:0] SS_SH    = 3'd2;
  localparam logic [2:0] SS_CERT  = 3'd3;
  localparam logic [2:0] SS_DONE  = 3'd4;
  localparam logic [2:0] SS_APP   = 3'd5;
  localparam logic [2:0] SS_ALERT = 3'd6;

  // classified item passed from front to back
  typedef struct packed {
    logic        hdr;     // header completed (starts a record)
    logic        last;    // record ends with this item
    logic [7:0]  data;
    logic [14:0] off;     // body offset of data byte
    logic [7:0]  ctype;
    logic [15:0] ver;
    logic [14:0] len;
  } trd_item_t;

endpackage

### design/trd_front.sv
// ----------------------------------------------------------------------------
// tls record deframer front end
// Hunts record headers in a sliding window and tags body bytes with offsets.
// ----------------------------------------------------------------------------
module trd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [14:0]        max_len,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               q_valid,
  input  logic               q_full,
  output trd_pkg::trd_item_t q_item
);
  import trd_pkg::*;

  logic [7:0]  win_r [4];
  logic [2:0]  fill_r;
  logic        body_r;
  logic [14:0] off_r;
  logic [7:0]  ct_r;
  logic [15:0] ver_r;
  logic [14:0] len_r;

  logic        acc;
  logic [15:0] v, l;
  logic        good;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // header check on the four held bytes plus the new one
  assign v = {win_r[1], win_r[2]};
  assign l = {win_r[3], in_data_byte};
  assign good = (win_r[0] >= CT_CCS) && (win_r[0] <= CT_HB) && (v >= VER_LO) &&
                (v <= VER_HI) && (l <= {1'b0, max_len}) && (l <= {1'b0, REC_CAP});

  always_comb begin
    q_item       = '0;
    q_item.data  = in_data_byte;
    q_item.ctype = body_r ? ct_r : win_r[0];
    q_item.ver   = body_r ? ver_r : v;
    q_item.len   = body_r ? len_r : l[14:0];
    q_item.off   = off_r;
    q_item.hdr   = !body_r;
    q_item.last  = body_r ? ({1'b0, off_r} + 16'd1 >= {1'b0, len_r}) : (l == 16'd0);
    q_valid      = acc && (body_r || (fill_r == 3'd4 && good));
  end

  // window, phase and offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      body_r <= 1'b0;
      off_r  <= '0;
    end else if (acc) begin
      if (body_r) begin
        off_r <= off_r + 15'd1;
        if ({1'b0, off_r} + 16'd1 >= {1'b0, len_r}) body_r <= 1'b0;
      end else if (fill_r < 3'd4) begin
        win_r[fill_r[1:0]] <= in_data_byte;
        fill_r <= fill_r + 3'd1;
      end else if (good) begin
        fill_r <= '0;
        off_r  <= '0;
        ct_r   <= win_r[0];
        ver_r  <= v;
        len_r  <= l[14:0];
        body_r <= (l != 16'd0);
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= in_data_byte;
      end
    end
  end
endmodule

### design/trd_queue.sv
// ----------------------------------------------------------------------------
// tls record deframer queue
// Two-entry queue between front classifier and back engine.
// ----------------------------------------------------------------------------
module trd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  trd_pkg::trd_item_t wr_item,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output trd_pkg::trd_item_t rd_item
);
  import trd_pkg::*;

  trd_item_t mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];

  // storage and pointers
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

### design/trd_back.sv
// ----------------------------------------------------------------------------
// tls record deframer back end
// Checks record bodies, keeps session state and counters, emits summaries.
// ----------------------------------------------------------------------------
module trd_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_rd,
  input  trd_pkg::trd_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_record_type,
  output logic [2:0]         out_version_code,
  output logic [14:0]        out_record_length,
  output logic               out_record_ok,
  output logic [7:0]         out_handshake_type,
  output logic [2:0]         out_session_state,
  output logic [2:0]         out_agreed_version,
  output logic [15:0]        out_negotiated_cipher,
  output logic [15:0]        out_handshake_count,
  output logic [15:0]        out_app_data_count,
  output logic [15:0]        out_alert_count,
  output logic [7:0]         out_alert_code
);
  import trd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic        bad_r;
  logic [7:0]  kind_r;
  logic [23:0] sub_r;
  logic [31:0] hf_r;
  logic [2:0]  step_r;
  logic [15:0] mark_r;
  logic [2:0]  st_r;
  logic [2:0]  nv_r;
  logic [15:0] nc_r;
  logic [COUNT_WIDTH-1:0] hc_r, ac_r, lc_r;

  logic        bad_nxt;
  logic [7:0]  kind_nxt;
  logic [23:0] sub_nxt;
  logic [31:0] hf_nxt;
  logic [2:0]  step_nxt;
  logic [15:0] mark_nxt;
  logic [2:0]  st_nxt, nv_nxt;
  logic [15:0] nc_nxt;
  logic [COUNT_WIDTH-1:0] hc_nxt, ac_nxt, lc_nxt;
  logic        ok;
  logic [7:0]  hst, acode;

  logic        go;
  logic [7:0]  b;
  logic [14:0] off;
  logic [23:0] n, p, len24, e;
  logic [15:0] c, vv;

  assign q_rd = q_valid && !(out_valid && out_stall);
  assign go   = q_rd;

  always_comb begin
    bad_nxt = bad_r; kind_nxt = kind_r; sub_nxt = sub_r; hf_nxt = hf_r;
    step_nxt = step_r; mark_nxt = mark_r;
    st_nxt = st_r; nv_nxt = nv_r; nc_nxt = nc_r;
    hc_nxt = hc_r; ac_nxt = ac_r; lc_nxt = lc_r;
    ok = 1'b0; hst = '0; acode = '0;
    b = q_item.data; off = q_item.off;
    len24 = {9'd0, q_item.len};
    n = sub_r; p = {9'd0, off} - 24'd4;
    c = '0; e = '0; vv = '0;
    // header: clear per-record context
    if (q_item.hdr) begin
      bad_nxt = (q_item.ctype == CT_HS) && (q_item.len < 15'd4);
      kind_nxt = '0; sub_nxt = '0; hf_nxt = '0; step_nxt = '0; mark_nxt = '0;
    end else begin
      case (q_item.ctype)
        CT_HS: begin
          if (!bad_r) begin
            if (off == 15'd0) kind_nxt = b;
            else if (off <= 15'd3) begin
              sub_nxt = {sub_r[15:0], b};
              if (off == 15'd3) begin
                if (kind_r == HS_UNKNOWN || sub_nxt == 24'd0 || sub_nxt > len24 - 24'd4)
                  bad_nxt = 1'b1;
                else if ((kind_r == HS_CH || kind_r == HS_SH) && sub_nxt < HELLO_MIN)
                  bad_nxt = 1'b1;
                else if (kind_r == HS_CERT && sub_nxt < 24'd6) bad_nxt = 1'b1;
              end
            end else if (p < n) begin
              case (kind_r)
                HS_CH: begin
                  if (step_r == 3'd0 && p == 24'd34) begin
                    if (24'd37 + {16'd0, b} > n) bad_nxt = 1'b1;
                    else begin mark_nxt = 16'd35 + {8'd0, b}; step_nxt = 3'd1; end
                  end else if (step_r == 3'd1 && p == {8'd0, mark_r}) begin
                    hf_nxt = {24'd0, b}; step_nxt = 3'd2;
                  end else if (step_r == 3'd2 && p == {8'd0, mark_r} + 24'd1) begin
                    c = {hf_r[7:0], b};
                    if (c[0] || p + 24'd1 + {8'd0, c} >= n) bad_nxt = 1'b1;
                    else begin mark_nxt = p[15:0] + 16'd1 + c; step_nxt = 3'd3; end
                  end else if (step_r == 3'd3 && p == {8'd0, mark_r}) begin
                    e = p + 24'd1 + {16'd0, b};
                    if (e > n || e == n - 24'd1) bad_nxt = 1'b1;
                    step_nxt = 3'd4;
                  end
                end
                HS_SH: begin
                  if (p < 24'd2) hf_nxt = {hf_r[23:16], b, hf_r[15:0]};
                  else if (step_r == 3'd0 && p == 24'd34) begin
                    if (24'd38 + {16'd0, b} > n || 24'd38 + {16'd0, b} == n - 24'd1)
                      bad_nxt = 1'b1;
                    else begin mark_nxt = 16'd35 + {8'd0, b}; step_nxt = 3'd1; end
                  end else if (step_r == 3'd1 && p == {8'd0, mark_r}) begin
                    hf_nxt = {hf_r[31:16], b, 8'd0}; step_nxt = 3'd2;
                  end else if (step_r == 3'd2 && p == {8'd0, mark_r} + 24'd1) begin
                    hf_nxt = {hf_r[31:8], b}; step_nxt = 3'd3;
                  end
                end
                HS_CERT: begin
                  if (p <= 24'd5) begin
                    hf_nxt = {8'd0, hf_r[15:0], b};
                    if (p == 24'd2) begin
                      if (hf_nxt[23:0] + 24'd3 != n) bad_nxt = 1'b1;
                      hf_nxt = '0;
                    end else if (p == 24'd5) begin
                      // one extra bit so a huge entry length cannot wrap
                      if ({1'b0, hf_nxt[23:0]} + 25'd6 > {1'b0, n}) bad_nxt = 1'b1;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        CT_ALERT: if (off == 15'd1) hf_nxt = {24'd0, b};
        CT_CCS:   if (off == 15'd0 && b != 8'd1) bad_nxt = 1'b1;
        default: ;
      endcase
    end
    // record end: verdict and session update
    if (q_item.last) begin
      case (q_item.ctype)
        CT_CCS: ok = (q_item.len == 15'd1) && !bad_nxt;
        CT_ALERT: if (q_item.len == 15'd2) begin
          ok = 1'b1; acode = hf_nxt[7:0];
          if (lc_r != CMAX) lc_nxt = lc_r + 1'b1;
          st_nxt = SS_ALERT;
        end
        CT_HS: begin
          if (q_item.len >= 15'd4) hst = kind_nxt;
          if (q_item.len >= 15'd4 && !bad_nxt) begin
            ok = 1'b1;
            if (hc_r != CMAX) hc_nxt = hc_r + 1'b1;
            vv = hf_nxt[31:16];
            if (kind_nxt == HS_CH) st_nxt = SS_CH;
            else if (kind_nxt == HS_SH) begin
              st_nxt = SS_SH;
              nv_nxt = (vv >= VER_LO && vv <= VER_HI) ? 3'(vv - VER_LO) : VER_UNKNOWN;
              nc_nxt = hf_nxt[15:0];
            end else if (kind_nxt == HS_CERT) st_nxt = SS_CERT;
            else if (kind_nxt == HS_FIN) st_nxt = SS_DONE;
          end
        end
        CT_APP: begin
          ok = 1'b1;
          if (ac_r != CMAX) ac_nxt = ac_r + 1'b1;
          if (st_r == SS_DONE) st_nxt = SS_APP;
        end
        default: ;
      endcase
    end
  end

  // context, session and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0; kind_r <= '0; sub_r <= '0; hf_r <= '0; step_r <= '0;
      mark_r <= '0; st_r <= SS_IDLE; nv_r <= VER_UNKNOWN; nc_r <= '0;
      hc_r <= '0; ac_r <= '0; lc_r <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (go) begin
        bad_r <= bad_nxt; kind_r <= kind_nxt; sub_r <= sub_nxt; hf_r <= hf_nxt;
        step_r <= step_nxt; mark_r <= mark_nxt; st_r <= st_nxt; nv_r <= nv_nxt;
        nc_r <= nc_nxt; hc_r <= hc_nxt; ac_r <= ac_nxt; lc_r <= lc_nxt;
        if (q_item.last) begin
          out_valid <= 1'b1;
          out_record_type <= q_item.ctype;
          out_version_code <= 3'(q_item.ver - VER_LO);
          out_record_length <= q_item.len;
          out_record_ok <= ok;
          out_handshake_type <= hst;
          out_session_state <= st_nxt;
          out_agreed_version <= nv_nxt;
          out_negotiated_cipher <= nc_nxt;
          out_handshake_count <= 16'(hc_nxt);
          out_app_data_count <= 16'(ac_nxt);
          out_alert_count <= 16'(lc_nxt);
          out_alert_code <= acode;
        end
      end
    end
  end
endmodule

### design/tls_record_deframer_top.sv
// ----------------------------------------------------------------------------
// tls record deframer top level
// Byte-stream record header hunter and per-record summary generator.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the queue is full; each completed record
// yields one summary item, which passes through the queue and is registered
// at the output. The front end runs the header window, a two-entry queue
// decouples it from the back end, which checks bodies and keeps the session
// state and saturating counters. Input stalls only when the queue is full.
module tls_record_deframer_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_max_record_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_record_type,
  output logic [2:0]  out_version_code,
  output logic [14:0] out_record_length,
  output logic        out_record_ok,
  output logic [7:0]  out_handshake_type,
  output logic [2:0]  out_session_state,
  output logic [2:0]  out_agreed_version,
  output logic [15:0] out_negotiated_cipher,
  output logic [15:0] out_handshake_count,
  output logic [15:0] out_app_data_count,
  output logic [15:0] out_alert_count,
  output logic [7:0]  out_alert_code
);
  import trd_pkg::*;

  logic [14:0] max_len_r;
  logic        fq_valid, q_full, q_valid, q_rd;
  trd_item_t   fq_item, q_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= REC_CAP;
    else if (cfg_we) max_len_r <= cfg_max_record_length;
  end

  trd_front u_front (
    .clk, .rst_n, .max_len(max_len_r), .in_valid, .in_stall, .in_data_byte,
    .q_valid(fq_valid), .q_full, .q_item(fq_item)
  );

  trd_queue u_queue (
    .clk, .rst_n, .wr_en(fq_valid), .wr_item(fq_item), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_rd), .rd_item(q_item)
  );

  trd_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_rd, .q_item, .out_valid, .out_stall,
    .out_record_type, .out_version_code, .out_record_length, .out_record_ok,
    .out_handshake_type, .out_session_state, .out_agreed_version,
    .out_negotiated_cipher, .out_handshake_count, .out_app_data_count,
    .out_alert_count, .out_alert_code
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fq_valid && q_full)) else $error("queue written while full");
  a_sum_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_record_type >= CT_CCS && out_record_type <= CT_HB))
    else $error("summary with bad record type");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_record_length))
    else $error("stalled summary lost");
endmodule
